FILE: rtl/ymre_pkg.sv
// Package for the YMODEM receive engine: protocol bytes, result codes and types.
package ymre_pkg;

    // Block sizes and derived position limits
    localparam int SMALL_BLOCK_BYTES = 128;
    localparam int LARGE_BLOCK_BYTES = 1024;
    localparam int POS_W = 11;
    localparam int JUNK_LIMIT = 3;

    // Protocol bytes
    localparam logic [7:0] BYTE_SOH        = 8'h01;
    localparam logic [7:0] BYTE_STX        = 8'h02;
    localparam logic [7:0] BYTE_EOT        = 8'h04;
    localparam logic [7:0] BYTE_ACK        = 8'h06;
    localparam logic [7:0] BYTE_NAK        = 8'h15;
    localparam logic [7:0] BYTE_CA         = 8'h18;
    localparam logic [7:0] BYTE_C          = 8'h43;
    localparam logic [7:0] KEY_ABORT_UPPER = 8'h41;
    localparam logic [7:0] KEY_ABORT_LOWER = 8'h61;
    localparam logic [7:0] SEQ_INVERT      = 8'hff;
    localparam logic [7:0] MAX_ERR_RESET   = 8'd5;

    // Input event kinds
    localparam logic EVT_BYTE    = 1'b0;
    localparam logic EVT_TIMEOUT = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Session end codes
    localparam logic [1:0] END_DONE       = 2'd0;
    localparam logic [1:0] END_SENDER_ABT = 2'd1;
    localparam logic [1:0] END_USER_ABT   = 2'd2;
    localparam logic [1:0] END_ERRORS     = 2'd3;

    // One result beat, less the last flag
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       name_block;
        logic [1:0] end_code;
    } res_t;

    localparam res_t RES_NONE = '{kind: KIND_PAYLOAD, value: 8'h00, name_block: 1'b0,
                                  end_code: END_DONE};

    function automatic res_t reply(input logic [7:0] b);
        res_t r;
        r = '{kind: KIND_REPLY, value: b, name_block: 1'b0, end_code: END_DONE};
        return r;
    endfunction

    function automatic res_t finish(input logic [1:0] code);
        res_t r;
        r = '{kind: KIND_END, value: 8'h00, name_block: 1'b0, end_code: code};
        return r;
    endfunction

endpackage

FILE: rtl/ymre_if.sv
// Stream interfaces for the receive events and the result beats.

interface ymre_evt_if;
    logic       valid;
    logic       ready;
    logic       event_kind;
    logic [7:0] rx_byte;

    modport source (output valid, output event_kind, output rx_byte, input ready);
    modport sink   (input valid, input event_kind, input rx_byte, output ready);
endinterface

interface ymre_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_value;
    logic       name_block;
    logic [1:0] end_code;
    logic       last;

    modport source (output valid, output out_kind, output out_value, output name_block,
                    output end_code, output last, input ready);
    modport sink   (input valid, input out_kind, input out_value, input name_block,
                    input end_code, input last, output ready);
endinterface

FILE: rtl/ymodem_receive_engine_unit.sv
// YMODEM receive engine: header hunt, block collection, replies and session end.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  evt     | in  | event_kind, rx_byte (one received byte or a timeout)
//  res     | out | out_kind, out_value, name_block, end_code, last
//  cfg     | in  | cfg_we, cfg_wdata -> max_error_count
//
// Each event is decoded in the cycle it is accepted; its zero to three results
// sit in a result group register and leave one beat a cycle while res.ready is high.
// One event a cycle when each yields at most one result and res.ready stays high; an
// event that yields more results holds evt.ready low while the group drains.
// evt.ready is high when the group is empty or its last beat is taken now.
// Reset: max_error_count returns to 5, all session state clears, no results.
module ymodem_receive_engine_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    ymre_evt_if.sink   evt,
    ymre_res_if.source res
);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_BLOCK   = 4'b0010,
        PH_AFTERCA = 4'b0100,
        PH_BADBLK  = 4'b1000
    } phase_t;

    localparam logic [ymre_pkg::POS_W-1:0] SMALL_LAST_DATA =
        ymre_pkg::POS_W'(ymre_pkg::SMALL_BLOCK_BYTES + 1);
    localparam logic [ymre_pkg::POS_W-1:0] LARGE_LAST_DATA =
        ymre_pkg::POS_W'(ymre_pkg::LARGE_BLOCK_BYTES + 1);
    localparam logic [ymre_pkg::POS_W-1:0] SMALL_END =
        ymre_pkg::POS_W'(ymre_pkg::SMALL_BLOCK_BYTES + 3);
    localparam logic [ymre_pkg::POS_W-1:0] LARGE_END =
        ymre_pkg::POS_W'(ymre_pkg::LARGE_BLOCK_BYTES + 3);
    localparam logic [1:0] JUNK_TRIP = 2'(ymre_pkg::JUNK_LIMIT);

    // Session state
    phase_t                     phase_reg, phase_next;
    logic [1:0]                 junk_reg, junk_next;
    logic [ymre_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       large_reg, large_next;
    logic [7:0]                 seq_reg, seq_next;
    logic [7:0]                 expect_reg, expect_next;
    logic                       taken_reg, taken_next;
    logic                       accepted_reg, accepted_next;
    logic                       empty_reg, empty_next;
    logic [7:0]                 errcnt_reg, errcnt_next;
    logic                       started_reg, started_next;
    logic [7:0]                 max_err_reg;

    // Result group
    ymre_pkg::res_t             grp_reg [3];
    ymre_pkg::res_t             grp_next [3];
    logic [1:0]                 cnt_reg, cnt_next;
    logic [1:0]                 idx_reg;
    logic [1:0]                 n_res;

    logic                       evt_acc, res_acc, res_last;
    logic [8:0]                 err_sum;
    logic                       err_over;
    logic                       do_err, do_clear;
    logic [ymre_pkg::POS_W-1:0] last_data, end_pos;
    ymre_pkg::res_t             res_cur;

    assign res_last = (idx_reg == (cnt_reg - 2'd1));
    assign res_acc  = res.valid && res.ready;
    assign evt.ready = (cnt_reg == 2'd0) || (res_acc && res_last);
    assign evt_acc  = evt.valid && evt.ready;

    // Error count after one more error (counted only once started), and the limit check
    assign err_sum  = {1'b0, errcnt_reg} + {8'd0, started_reg};
    assign err_over = err_sum > {1'b0, max_err_reg};

    assign last_data = large_reg ? LARGE_LAST_DATA : SMALL_LAST_DATA;
    assign end_pos   = large_reg ? LARGE_END : SMALL_END;

    // Event decode: next state and result group
    always_comb
    begin
        phase_next    = phase_reg;
        junk_next     = junk_reg;
        pos_next      = pos_reg;
        large_next    = large_reg;
        seq_next      = seq_reg;
        expect_next   = expect_reg;
        taken_next    = taken_reg;
        accepted_next = accepted_reg;
        empty_next    = empty_reg;
        errcnt_next   = errcnt_reg;
        started_next  = started_reg;
        grp_next[0]   = ymre_pkg::RES_NONE;
        grp_next[1]   = ymre_pkg::RES_NONE;
        grp_next[2]   = ymre_pkg::RES_NONE;
        n_res         = 2'd0;
        do_err        = 1'b0;
        do_clear      = 1'b0;

        if (evt.event_kind == ymre_pkg::EVT_TIMEOUT)
        begin
            do_err = 1'b1;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_HUNT:
                begin
                    if (evt.rx_byte == ymre_pkg::BYTE_SOH || evt.rx_byte == ymre_pkg::BYTE_STX)
                    begin
                        large_next = (evt.rx_byte == ymre_pkg::BYTE_STX);
                        phase_next = PH_BLOCK;
                        pos_next   = '0;
                        junk_next  = 2'd0;
                    end
                    else if (evt.rx_byte == ymre_pkg::BYTE_EOT)
                    begin
                        junk_next   = 2'd0;
                        errcnt_next = 8'd0;
                        expect_next = 8'd0;
                        taken_next  = 1'b0;
                        grp_next[0] = ymre_pkg::reply(ymre_pkg::BYTE_ACK);
                        n_res       = 2'd1;
                    end
                    else if (evt.rx_byte == ymre_pkg::BYTE_CA)
                    begin
                        phase_next = PH_AFTERCA;
                        junk_next  = 2'd0;
                    end
                    else if (evt.rx_byte == ymre_pkg::KEY_ABORT_UPPER ||
                             evt.rx_byte == ymre_pkg::KEY_ABORT_LOWER)
                    begin
                        grp_next[0] = ymre_pkg::reply(ymre_pkg::BYTE_CA);
                        grp_next[1] = ymre_pkg::reply(ymre_pkg::BYTE_CA);
                        grp_next[2] = ymre_pkg::finish(ymre_pkg::END_USER_ABT);
                        n_res       = 2'd3;
                        do_clear    = 1'b1;
                    end
                    else
                    begin
                        junk_next = junk_reg + 2'd1;
                        if (junk_next == JUNK_TRIP)
                        begin
                            do_err = 1'b1;
                        end
                    end
                end
                PH_AFTERCA:
                begin
                    if (evt.rx_byte == ymre_pkg::BYTE_CA)
                    begin
                        grp_next[0] = ymre_pkg::reply(ymre_pkg::BYTE_ACK);
                        grp_next[1] = ymre_pkg::finish(ymre_pkg::END_SENDER_ABT);
                        n_res       = 2'd2;
                        do_clear    = 1'b1;
                    end
                    else
                    begin
                        do_err = 1'b1;
                    end
                end
                PH_BLOCK, PH_BADBLK:
                begin
                    // Sequence byte, complement, payload, then two CRC bytes
                    if (pos_reg == '0)
                    begin
                        seq_next = evt.rx_byte;
                    end
                    else if (pos_reg == ymre_pkg::POS_W'(1))
                    begin
                        if ((evt.rx_byte ^ ymre_pkg::SEQ_INVERT) != seq_reg)
                        begin
                            phase_next    = PH_BADBLK;
                            accepted_next = 1'b0;
                        end
                        else
                        begin
                            accepted_next = (seq_reg == expect_reg);
                        end
                    end
                    else if (pos_reg <= last_data)
                    begin
                        if (pos_reg == ymre_pkg::POS_W'(2))
                        begin
                            empty_next = (evt.rx_byte == 8'd0);
                        end
                        if (accepted_reg)
                        begin
                            grp_next[0] = '{kind: ymre_pkg::KIND_PAYLOAD, value: evt.rx_byte,
                                            name_block: !taken_reg,
                                            end_code: ymre_pkg::END_DONE};
                            n_res       = 2'd1;
                        end
                    end

                    if (pos_reg >= end_pos)
                    begin
                        // Block complete
                        phase_next = PH_HUNT;
                        junk_next  = 2'd0;
                        pos_next   = '0;
                        if (phase_reg == PH_BADBLK)
                        begin
                            do_err = 1'b1;
                        end
                        else
                        begin
                            errcnt_next = 8'd0;
                            if (seq_reg != expect_reg)
                            begin
                                grp_next[0] = ymre_pkg::reply(ymre_pkg::BYTE_NAK);
                                n_res       = 2'd1;
                            end
                            else if (!taken_reg && empty_reg)
                            begin
                                grp_next[0] = ymre_pkg::reply(ymre_pkg::BYTE_ACK);
                                grp_next[1] = ymre_pkg::finish(ymre_pkg::END_DONE);
                                n_res       = 2'd2;
                                do_clear    = 1'b1;
                            end
                            else
                            begin
                                grp_next[0] = ymre_pkg::reply(ymre_pkg::BYTE_ACK);
                                grp_next[1] = ymre_pkg::reply(ymre_pkg::BYTE_C);
                                n_res       = taken_reg ? 2'd1 : 2'd2;
                                expect_next = expect_reg + 8'd1;
                                taken_next  = 1'b1;
                                started_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + ymre_pkg::POS_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // Error event: retry with 'C' or cancel once over the limit
        if (do_err)
        begin
            phase_next = PH_HUNT;
            junk_next  = 2'd0;
            pos_next   = '0;
            if (err_over)
            begin
                grp_next[0] = ymre_pkg::reply(ymre_pkg::BYTE_CA);
                grp_next[1] = ymre_pkg::reply(ymre_pkg::BYTE_CA);
                grp_next[2] = ymre_pkg::finish(ymre_pkg::END_ERRORS);
                n_res       = 2'd3;
                do_clear    = 1'b1;
            end
            else
            begin
                errcnt_next = err_sum[7:0];
                grp_next[0] = ymre_pkg::reply(ymre_pkg::BYTE_C);
                n_res       = 2'd1;
            end
        end

        // Session end returns all session state to its reset value
        if (do_clear)
        begin
            phase_next    = PH_HUNT;
            junk_next     = 2'd0;
            pos_next      = '0;
            large_next    = 1'b0;
            seq_next      = 8'd0;
            expect_next   = 8'd0;
            taken_next    = 1'b0;
            accepted_next = 1'b0;
            empty_next    = 1'b0;
            errcnt_next   = 8'd0;
            started_next  = 1'b0;
        end
    end

    // Session state registers, updated on each accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            junk_reg     <= 2'd0;
            pos_reg      <= '0;
            large_reg    <= 1'b0;
            seq_reg      <= 8'd0;
            expect_reg   <= 8'd0;
            taken_reg    <= 1'b0;
            accepted_reg <= 1'b0;
            empty_reg    <= 1'b0;
            errcnt_reg   <= 8'd0;
            started_reg  <= 1'b0;
        end
        else if (evt_acc)
        begin
            phase_reg    <= phase_next;
            junk_reg     <= junk_next;
            pos_reg      <= pos_next;
            large_reg    <= large_next;
            seq_reg      <= seq_next;
            expect_reg   <= expect_next;
            taken_reg    <= taken_next;
            accepted_reg <= accepted_next;
            empty_reg    <= empty_next;
            errcnt_reg   <= errcnt_next;
            started_reg  <= started_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_err_reg <= ymre_pkg::MAX_ERR_RESET;
        end
        else if (cfg_we)
        begin
            max_err_reg <= cfg_wdata;
        end
    end

    // Result group count and read index
    always_comb
    begin
        cnt_next = cnt_reg;
        if (evt_acc)
        begin
            cnt_next = n_res;
        end
        else if (res_acc && res_last)
        begin
            cnt_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (evt_acc || (res_acc && res_last))
            begin
                idx_reg <= 2'd0;
            end
            else if (res_acc)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Result payload, loaded with the group
    always_ff @(posedge clk)
    begin
        if (evt_acc)
        begin
            grp_reg[0] <= grp_next[0];
            grp_reg[1] <= grp_next[1];
            grp_reg[2] <= grp_next[2];
        end
    end

    // Output beat selection
    always_comb
    begin
        case (idx_reg)
            2'd0:    res_cur = grp_reg[0];
            2'd1:    res_cur = grp_reg[1];
            default: res_cur = grp_reg[2];
        endcase
    end

    assign res.valid      = (cnt_reg != 2'd0);
    assign res.out_kind   = res_cur.kind;
    assign res.out_value  = res_cur.value;
    assign res.name_block = res_cur.name_block;
    assign res.end_code   = res_cur.end_code;
    assign res.last       = res_last;

    // Read index stays inside the group
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd0) |-> (idx_reg < cnt_reg))
        else $error("result index beyond group");

    // A session end is always the final beat of its event
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.out_kind == ymre_pkg::KIND_END) |-> res.last)
        else $error("session end not marked last");

    // No new event while earlier beats of a group are pending
    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        evt.ready |-> !(res.valid && !res.ready) && !(res.valid && !res.last))
        else $error("event taken before group drained");

    // A stalled group keeps its place
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> (res.valid && $stable(idx_reg) && $stable(cnt_reg)))
        else $error("result group moved under stall");

    // Session end leaves the engine hunting with a clear error count
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_acc && do_clear) |=> (phase_reg == PH_HUNT && errcnt_reg == 8'd0 && !started_reg))
        else $error("state not cleared after session end");

endmodule

FILE: test/ymre_result_checker.sv
// Result checker for the YMODEM receive engine: predicts each beat and compares it.
`timescale 1ns / 1ps

module ymre_result_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    ymre_evt_if        evt,
    ymre_res_if        res,
    output int         pending,
    output int         fail_count
);

    // Receive phases of the predictor
    typedef enum logic [3:0] {
        PH_HUNT      = 4'b0001,
        PH_BLOCK     = 4'b0010,
        PH_CA_SEEN   = 4'b0100,
        PH_BAD_BLOCK = 4'b1000
    } pred_phase_t;

    typedef struct packed {
        ymre_pkg::res_t r;
        logic           last;
    } beat_t;

    // Predictor state
    logic [7:0]  err_limit;
    pred_phase_t phase;
    logic [1:0]  junk;
    logic [10:0] pos;
    logic        big_block;
    logic [7:0]  seq_byte;
    logic [7:0]  want_seq;
    logic        name_done;
    logic        payload_on;
    logic        name_zero;
    logic [7:0]  err_cnt;
    logic        started;

    beat_t step_beats [3];
    int    step_n;
    beat_t beats_due [$];
    int    mismatches;

    function automatic void clear_session();
        phase      = PH_HUNT;
        junk       = '0;
        pos        = '0;
        big_block  = 1'b0;
        seq_byte   = '0;
        want_seq   = '0;
        name_done  = 1'b0;
        payload_on = 1'b0;
        name_zero  = 1'b0;
        err_cnt    = '0;
        started    = 1'b0;
    endfunction

    // At most three beats per event; anything further is dropped
    function automatic void push_beat(input logic [1:0] kind, input logic [7:0] value,
                                      input logic nb, input logic [1:0] code);
        if (step_n < 3)
        begin
            step_beats[step_n] = '{r: '{kind: kind, value: value, name_block: nb,
                                        end_code: code}, last: 1'b0};
            step_n++;
        end
    endfunction

    function automatic void end_session(input logic [1:0] code);
        push_beat(ymre_pkg::KIND_END, 8'h00, 1'b0, code);
        clear_session();
    endfunction

    function automatic void push_reply(input logic [7:0] b);
        push_beat(ymre_pkg::KIND_REPLY, b, 1'b0, ymre_pkg::END_DONE);
    endfunction

    // Timeout, stray byte after CA, junk run or bad complement
    function automatic void count_error();
        int next_cnt;
        next_cnt = int'(err_cnt) + (started ? 1 : 0);
        phase = PH_HUNT;
        junk  = '0;
        pos   = '0;
        if (next_cnt > int'(err_limit))
        begin
            push_reply(ymre_pkg::BYTE_CA);
            push_reply(ymre_pkg::BYTE_CA);
            end_session(ymre_pkg::END_ERRORS);
        end
        else
        begin
            err_cnt = 8'(next_cnt);
            push_reply(ymre_pkg::BYTE_C);
        end
    endfunction

    function automatic void close_block();
        logic bad;
        bad   = (phase == PH_BAD_BLOCK);
        phase = PH_HUNT;
        junk  = '0;
        pos   = '0;
        if (bad)
        begin
            count_error();
            return;
        end
        err_cnt = '0;
        if (seq_byte != want_seq)
        begin
            push_reply(ymre_pkg::BYTE_NAK);
            return;
        end
        if (!name_done)
        begin
            if (name_zero)
            begin
                push_reply(ymre_pkg::BYTE_ACK);
                end_session(ymre_pkg::END_DONE);
                return;
            end
            push_reply(ymre_pkg::BYTE_ACK);
            push_reply(ymre_pkg::BYTE_C);
        end
        else
        begin
            push_reply(ymre_pkg::BYTE_ACK);
        end
        want_seq  = want_seq + 8'd1;
        name_done = 1'b1;
        started   = 1'b1;
    endfunction

    function automatic void hunt_step(input logic [7:0] b);
        if (b == ymre_pkg::BYTE_SOH || b == ymre_pkg::BYTE_STX)
        begin
            big_block = (b == ymre_pkg::BYTE_STX);
            phase     = PH_BLOCK;
            pos       = '0;
            junk      = '0;
        end
        else if (b == ymre_pkg::BYTE_EOT)
        begin
            junk      = '0;
            err_cnt   = '0;
            want_seq  = '0;
            name_done = 1'b0;
            push_reply(ymre_pkg::BYTE_ACK);
        end
        else if (b == ymre_pkg::BYTE_CA)
        begin
            phase = PH_CA_SEEN;
            junk  = '0;
        end
        else if (b == ymre_pkg::KEY_ABORT_UPPER || b == ymre_pkg::KEY_ABORT_LOWER)
        begin
            push_reply(ymre_pkg::BYTE_CA);
            push_reply(ymre_pkg::BYTE_CA);
            end_session(ymre_pkg::END_USER_ABT);
        end
        else
        begin
            junk = junk + 2'd1;
            if (int'(junk) >= ymre_pkg::JUNK_LIMIT)
                count_error();
        end
    endfunction

    // Sequence, complement, payload, then two CRC bytes
    function automatic void block_step(input logic [7:0] b);
        int size;
        int p;
        size = big_block ? ymre_pkg::LARGE_BLOCK_BYTES : ymre_pkg::SMALL_BLOCK_BYTES;
        p    = int'(pos);
        if (p == 0)
        begin
            seq_byte = b;
        end
        else if (p == 1)
        begin
            if ((b ^ ymre_pkg::SEQ_INVERT) != seq_byte)
            begin
                phase      = PH_BAD_BLOCK;
                payload_on = 1'b0;
            end
            else
            begin
                payload_on = (seq_byte == want_seq);
            end
        end
        else if (p <= size + 1)
        begin
            if (p == 2)
                name_zero = (b == 8'h00);
            if (payload_on)
                push_beat(ymre_pkg::KIND_PAYLOAD, b, !name_done, ymre_pkg::END_DONE);
        end
        if (p >= size + 3)
        begin
            close_block();
            return;
        end
        pos = 11'(p + 1);
    endfunction

    function automatic void predict_event(input logic kind, input logic [7:0] b);
        step_n = 0;
        if (kind == ymre_pkg::EVT_TIMEOUT)
            count_error();
        else if (phase == PH_HUNT)
            hunt_step(b);
        else if (phase == PH_CA_SEEN)
        begin
            if (b == ymre_pkg::BYTE_CA)
            begin
                err_cnt = '0;
                push_reply(ymre_pkg::BYTE_ACK);
                end_session(ymre_pkg::END_SENDER_ABT);
            end
            else
            begin
                count_error();
            end
        end
        else
            block_step(b);
        if (step_n > 0)
            step_beats[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            beats_due.push_back(step_beats[i]);
    endfunction

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        beat_t want;
        if (!rst_n)
        begin
            err_limit = ymre_pkg::MAX_ERR_RESET;
            clear_session();
            beats_due.delete();
            mismatches = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
                err_limit = cfg_wdata;
            if (evt.valid && evt.ready)
                predict_event(evt.event_kind, evt.rx_byte);
            if (res.valid && res.ready)
            begin
                if (beats_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no beat, actual kind %0d value %02h nb %0b code %0d",
                             $time, res.out_kind, res.out_value, res.name_block,
                             res.end_code);
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (res.out_kind !== want.r.kind || res.out_value !== want.r.value ||
                        res.name_block !== want.r.name_block ||
                        res.end_code !== want.r.end_code || res.last !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: expected kind %0d value %02h nb %0b code %0d last %0b",
                                 $time, want.r.kind, want.r.value, want.r.name_block,
                                 want.r.end_code, want.last);
                        $display("%0t: actual   kind %0d value %02h nb %0b code %0d last %0b",
                                 $time, res.out_kind, res.out_value, res.name_block,
                                 res.end_code, res.last);
                    end
                end
            end
            pending    <= beats_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

FILE: test/testbench.sv
// Testbench top for the YMODEM receive engine: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int  HOLD_CYCLES  = 400;
    localparam int  PHASE_ITEMS  = 30;
    localparam real RUN_LIMIT_NS = 10_000_000.0;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         beats_pending;
    int         fail_count;

    int         idle_pct = 0;
    int         stall_pct = 0;
    int         hold_requests = 0;
    logic       hold_active = 1'b0;
    int         items_sent = 0;
    logic [7:0] next_seq = 8'h00;

    ymre_evt_if evt_ch ();
    ymre_res_if res_ch ();

    ymodem_receive_engine_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .evt       (evt_ch),
        .res       (res_ch)
    );

    ymre_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .evt        (evt_ch),
        .res        (res_ch),
        .pending    (beats_pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL ymodem_receive_engine_unit");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= rst_n && !hold_active && ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int served;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served++;
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
            end
        end
    end

    // One event beat, with random gaps before it
    task automatic send_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.event_kind <= kind;
        evt_ch.rx_byte    <= b;
        @(posedge clk);
        while (!evt_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_octet(input logic [7:0] b);
        send_item(ymre_pkg::EVT_BYTE, b);
    endtask

    task automatic send_timeout();
        send_item(ymre_pkg::EVT_TIMEOUT, 8'($urandom_range(255)));
    endtask

    // Header, sequence, complement, payload, CRC; cut_at > 0 ends in a timeout
    task automatic send_block(input logic big, input logic [7:0] seq, input logic compl_ok,
                              input int first_pay, input int cut_at);
        int         total;
        logic [7:0] b;
        total = (big ? ymre_pkg::LARGE_BLOCK_BYTES : ymre_pkg::SMALL_BLOCK_BYTES) + 4;
        send_octet(big ? ymre_pkg::BYTE_STX : ymre_pkg::BYTE_SOH);
        for (int i = 0; i < total; i++)
        begin
            if (cut_at != 0 && i == cut_at)
            begin
                send_timeout();
                return;
            end
            if (i == 0)
                b = seq;
            else if (i == 1)
                b = compl_ok ? ~seq : (~seq ^ (8'h01 << $urandom_range(7)));
            else if (i == 2 && first_pay >= 0)
                b = 8'(first_pay);
            else
                b = 8'($urandom_range(255));
            send_octet(b);
        end
    endtask

    // Well-formed block with the sequence the engine should be expecting
    task automatic send_good_block(input logic big);
        send_block(big, next_seq, 1'b1, int'($urandom_range(1, 255)), 0);
        next_seq = next_seq + 8'd1;
    endtask

    task automatic wait_idle();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_idle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Short events and blocks broken off early by a timeout
    task automatic run_traffic(input int budget);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                send_block(1'($urandom_range(1)), next_seq + 8'($urandom_range(1)),
                           1'($urandom_range(1)), -1, int'($urandom_range(1, 8)));
            end
            else if (pick < 35)
            begin
                send_octet(ymre_pkg::BYTE_EOT);
                next_seq = 8'h00;
            end
            else if (pick < 45)
            begin
                send_octet(ymre_pkg::BYTE_CA);
                send_octet(ymre_pkg::BYTE_CA);
                next_seq = 8'h00;
            end
            else if (pick < 55)
            begin
                send_octet(ymre_pkg::BYTE_CA);
                send_octet(8'($urandom_range(255)));
            end
            else if (pick < 62)
            begin
                send_octet($urandom_range(1) ? ymre_pkg::KEY_ABORT_UPPER :
                                               ymre_pkg::KEY_ABORT_LOWER);
                next_seq = 8'h00;
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4)) send_octet(8'($urandom_range(255)));
            end
            else
            begin
                send_timeout();
            end
        end
    endtask

    initial
    begin
        logic [7:0] limits [4];
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= 8'h00;
        evt_ch.valid      <= 1'b0;
        evt_ch.event_kind <= ymre_pkg::EVT_BYTE;
        evt_ch.rx_byte    <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: timeout, junk run, abort keys, CA pair, stray CA, EOT, cut blocks
        send_timeout();
        send_octet(8'hff);
        send_octet(8'h00);
        send_octet(8'h80);
        send_octet(ymre_pkg::KEY_ABORT_UPPER);
        send_octet(ymre_pkg::KEY_ABORT_LOWER);
        send_octet(ymre_pkg::BYTE_CA);
        send_octet(ymre_pkg::BYTE_CA);
        send_octet(ymre_pkg::BYTE_CA);
        send_octet(8'h55);
        send_octet(ymre_pkg::BYTE_EOT);
        send_octet(ymre_pkg::BYTE_SOH);
        send_timeout();
        send_octet(ymre_pkg::BYTE_STX);
        send_octet(8'h00);
        send_timeout();
        next_seq = 8'h00;

        // Name block, one data block, then end of file
        write_limit(8'd255);
        send_good_block(1'b0);
        send_good_block(1'b0);
        send_octet(ymre_pkg::BYTE_EOT);
        next_seq = 8'h00;

        // Random phases over idling modes and error limits
        limits[0] = 8'd0;
        limits[1] = 8'd1;
        limits[2] = 8'($urandom_range(2, 254));
        limits[3] = 8'd3;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_limit(limits[ph]);
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct  = 66;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct <= 66;
                end
                default:
                begin
                    idle_pct  = 20;
                    stall_pct <= 20;
                end
            endcase
            if (ph == 2)
            begin
                hold_requests <= hold_requests + 1;
                repeat (24) send_timeout();
            end
            run_traffic(PHASE_ITEMS);
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS ymodem_receive_engine_unit");
        else
            $display("FAIL ymodem_receive_engine_unit");
        $finish;
    end

endmodule

FILE: ymodem_receive_engine_unit.f
rtl/ymre_pkg.sv
rtl/ymre_if.sv
rtl/ymodem_receive_engine_unit.sv
test/ymre_result_checker.sv
test/testbench.sv
